// ----- rtl/piecewise_hazard_event_sampler_core_defines.svh -----
// Assertion macros shared by the event sampler RTL.
// No dependencies; files that check their logic include this header.
`ifndef PIECEWISE_HAZARD_EVENT_SAMPLER_CORE_DEFINES_SVH
`define PIECEWISE_HAZARD_EVENT_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PHES_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PHES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/phes_pkg.sv -----
// Types, constants and state encodings for the event sampler.
// No dependencies; used by every module of the block.
package phes_pkg;

   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [31:0] TIME_MAX   = 32'hFFFF_FFFF;
   localparam logic [39:0] CUM_MAX    = 40'hFF_FFFF_FFFF;
   localparam int          FIFO_DEPTH = 4;
   localparam int          LOG_STEPS  = 24;
   localparam int          DIV_STEPS  = 48;

   typedef struct packed {
      logic [31:0] uniform_draw;
      logic        first_interval;
      logic [31:0] interval_end;
      logic [31:0] hazard_rate;
      logic        last_interval;
   } req_type;

   typedef struct packed {
      logic [31:0] event_time;
      logic        never_happened;
   } rsp_type;

   // One classified interval, as queued between front and back.
   typedef struct packed {
      logic        first;
      logic        last;
      logic [31:0] end_time;
      logic [31:0] hazard;
      logic [31:0] target;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_NORM,
      F_LOG,
      F_SCALE,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_TEST,
      B_DIV,
      B_SUM,
      B_FIN
   } back_state_type;

endpackage

// ----- rtl/phes_fifo.sv -----
// Short queue of classified intervals between front and back.
// Depends on phes_pkg and the assertion macro header.
`include "piecewise_hazard_event_sampler_core_defines.svh"

module phes_fifo #(
   parameter int DEPTH = phes_pkg::FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  phes_pkg::qent_type    push_data,
   input  logic                  pop,
   output phes_pkg::qent_type    pop_data,
   output phes_pkg::fifo_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   phes_pkg::qent_type mem [DEPTH];
   phes_pkg::qent_type rd_data_ff;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_data   = rd_data_ff;
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   `PHES_ASSERT_NOW(a_no_overflow, clock, reset, push, !stat.full, "push into full queue")
   `PHES_ASSERT_NOW(a_no_underflow, clock, reset, pop, !stat.empty, "pop from empty queue")

endmodule

// ----- rtl/phes_front.sv -----
// Front end: accepts intervals and forms the target -ln(u) on a first interval.
// Depends on phes_pkg; pushes classified intervals into phes_fifo.
module phes_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  phes_pkg::req_type       req_data,
   output logic                    push,
   output phes_pkg::qent_type      push_data,
   input  phes_pkg::fifo_stat_type fifo_stat
);

   phes_pkg::front_state_type state_ff, state_in;
   phes_pkg::qent_type        item_ff, item_in;
   logic [31:0] x_ff, x_in;
   logic [4:0]  msb_ff, msb_in;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  step_ff, step_in;

   logic        accept;
   logic [63:0] sq;
   logic [32:0] sq_shr;
   logic [29:0] lval;
   logic [61:0] scaled;
   logic [29:0] tval;

   assign req_stall = (state_ff != phes_pkg::F_IDLE);
   assign accept    = req_valid && !req_stall;
   assign push      = (state_ff == phes_pkg::F_PUSH) && !fifo_stat.full;
   assign push_data = item_ff;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      x_in     = x_ff;
      msb_in   = msb_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      sq       = 64'(x_ff) * 64'(x_ff);
      sq_shr   = sq[63:31];
      lval     = 30'(32'd32 << 24) - {1'b0, msb_ff, frac_ff};
      scaled   = 62'(lval) * 62'(phes_pkg::LN2_Q32);
      tval     = scaled[61:32];
      case (state_ff)
         phes_pkg::F_IDLE: begin
            if (accept) begin
               item_in.first    = req_data.first_interval;
               item_in.last     = req_data.last_interval;
               item_in.end_time = req_data.interval_end;
               item_in.hazard   = req_data.hazard_rate;
               item_in.target   = phes_pkg::TIME_MAX;
               x_in             = req_data.uniform_draw;
               msb_in           = 5'd31;
               frac_in          = '0;
               step_in          = '0;
               if (req_data.first_interval && req_data.uniform_draw != '0) begin
                  state_in = phes_pkg::F_NORM;
               end else begin
                  state_in = phes_pkg::F_PUSH;
               end
            end
         end
         phes_pkg::F_NORM: begin
            // shift the draw up to Q1.31, tracking its top bit position
            if (x_ff[31]) begin
               state_in = phes_pkg::F_LOG;
            end else begin
               x_in   = {x_ff[30:0], 1'b0};
               msb_in = msb_ff - 5'd1;
            end
         end
         phes_pkg::F_LOG: begin
            // one fraction bit of log2 per squaring
            if (sq_shr[32]) begin
               x_in    = sq_shr[32:1];
               frac_in = {frac_ff[22:0], 1'b1};
            end else begin
               x_in    = sq_shr[31:0];
               frac_in = {frac_ff[22:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(phes_pkg::LOG_STEPS - 1)) begin
               state_in = phes_pkg::F_SCALE;
            end
         end
         phes_pkg::F_SCALE: begin
            item_in.target = (tval == '0) ? 32'd1 : 32'(tval);
            state_in       = phes_pkg::F_PUSH;
         end
         phes_pkg::F_PUSH: begin
            if (!fifo_stat.full) begin
               state_in = phes_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = phes_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phes_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      x_ff    <= x_in;
      msb_ff  <= msb_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

endmodule

// ----- rtl/phes_back.sv -----
// Back end: accumulates hazard, locates the event, divides, and emits results.
// Depends on phes_pkg and the assertion macro header; pops from phes_fifo.
`include "piecewise_hazard_event_sampler_core_defines.svh"

module phes_back (
   input  logic                    clock,
   input  logic                    reset,
   input  phes_pkg::fifo_stat_type fifo_stat,
   output logic                    pop,
   input  phes_pkg::qent_type      pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output phes_pkg::rsp_type       rsp_data
);

   phes_pkg::back_state_type state_ff, state_in;
   logic [31:0] target_ff, target_in;
   logic [39:0] cum_ff, cum_in;
   logic [31:0] prev_ff, prev_in;
   logic        found_ff, found_in;
   logic [31:0] held_ff, held_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [47:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   phes_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] dt;
   logic [47:0] inc_raw;
   logic [39:0] inc;
   logic [40:0] next_sum;
   logic [39:0] next_cum;
   logic [32:0] trial;
   logic        ge;
   logic [48:0] tm;
   logic        slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == phes_pkg::B_IDLE) && !fifo_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      cum_in       = cum_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      held_in      = held_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      dt       = (pop_data.end_time > prev_ff) ? pop_data.end_time - prev_ff : '0;
      inc_raw  = prod_ff[63:16];
      inc      = (inc_raw > 48'(phes_pkg::CUM_MAX)) ? phes_pkg::CUM_MAX : inc_raw[39:0];
      next_sum = 41'(cum_ff) + 41'(inc);
      next_cum = next_sum[40] ? phes_pkg::CUM_MAX : next_sum[39:0];
      trial    = {rem_ff, dvd_ff[47]};
      ge       = (trial >= {1'b0, pop_data.hazard});
      tm       = 49'(quo_ff) + 49'(prev_ff);

      case (state_ff)
         phes_pkg::B_IDLE: begin
            if (!fifo_stat.empty) begin
               state_in = phes_pkg::B_MUL;
            end
         end
         phes_pkg::B_MUL: begin
            // a first interval opens a new observation
            if (pop_data.first) begin
               target_in = pop_data.target;
               cum_in    = '0;
               prev_in   = '0;
               found_in  = 1'b0;
               held_in   = '0;
               prod_in   = 64'(pop_data.hazard) * 64'(pop_data.end_time);
            end else begin
               prod_in   = 64'(pop_data.hazard) * 64'(dt);
            end
            state_in = phes_pkg::B_TEST;
         end
         phes_pkg::B_TEST: begin
            state_in = phes_pkg::B_FIN;
            if (!found_ff) begin
               if (next_cum >= 40'(target_ff) && pop_data.hazard != '0) begin
                  rem_in   = '0;
                  dvd_in   = {target_ff - cum_ff[31:0], 16'h0000};
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = phes_pkg::B_DIV;
               end else begin
                  cum_in = next_cum;
               end
            end
         end
         phes_pkg::B_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in = ge ? 32'(trial - {1'b0, pop_data.hazard}) : trial[31:0];
            quo_in = {quo_ff[46:0], ge};
            dvd_in = {dvd_ff[46:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(phes_pkg::DIV_STEPS - 1)) begin
               state_in = phes_pkg::B_SUM;
            end
         end
         phes_pkg::B_SUM: begin
            held_in  = (tm > 49'(phes_pkg::TIME_MAX)) ? phes_pkg::TIME_MAX : tm[31:0];
            found_in = 1'b1;
            state_in = phes_pkg::B_FIN;
         end
         phes_pkg::B_FIN: begin
            if (!pop_data.last) begin
               prev_in  = pop_data.end_time;
               state_in = phes_pkg::B_IDLE;
            end else if (slot_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.event_time     = found_ff ? held_ff : '0;
               rsp_data_in.never_happened = !found_ff;
               cum_in   = '0;
               prev_in  = '0;
               found_in = 1'b0;
               held_in  = '0;
               state_in = phes_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = phes_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= phes_pkg::B_IDLE;
         target_ff    <= '0;
         cum_ff       <= '0;
         prev_ff      <= '0;
         found_ff     <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         cum_ff       <= cum_in;
         prev_ff      <= prev_in;
         found_ff     <= found_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PHES_ASSERT_NOW(a_cum_below_target, clock, reset, 1'b1, cum_ff <= 40'(target_ff), "cumulative hazard passed target")
   `PHES_ASSERT_NEXT(a_div_exit, clock, reset, state_ff == phes_pkg::B_DIV, state_ff == phes_pkg::B_DIV || state_ff == phes_pkg::B_SUM, "divider left early")
   `PHES_ASSERT_NEXT(a_found_sets, clock, reset, state_ff == phes_pkg::B_SUM, found_ff, "event not recorded after divide")

endmodule

// ----- rtl/piecewise_hazard_event_sampler_core.sv -----
// Piecewise hazard event sampler, top level.
// Each interval passes the back states multiply, test and finish; a first interval with a nonzero
// draw first goes through front normalise, log and scale for -ln(u); the event's interval adds
// the divider and a sum step. The front takes one interval at a time; the queue decouples them.
// Reset clears all control state, the sum, target and held time; no clearing pass.
// Depends on phes_pkg, phes_front, phes_fifo and phes_back.
module piecewise_hazard_event_sampler_core #(
   parameter int FIFO_DEPTH = phes_pkg::FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  phes_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output phes_pkg::rsp_type rsp_data
);

   logic                    push;
   logic                    pop;
   phes_pkg::qent_type      push_data;
   phes_pkg::qent_type      pop_data;
   phes_pkg::fifo_stat_type fifo_stat;

   phes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .fifo_stat (fifo_stat)
   );

   phes_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   phes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
